FILE: rtl/core/upn_pkg.sv
package upn_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_QM    = 8'h3F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_CASE  = 8'h20;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_ESC   = 2'd1,
        ERR_ROOT  = 2'd2,
        ERR_OVF   = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        PS_USUAL   = 3'd0,
        PS_SLASH   = 3'd1,
        PS_DOT     = 3'd2,
        PS_DOTDOT  = 3'd3,
        PS_QUOTED  = 3'd4,
        PS_QUOTED2 = 3'd5
    } t_pstate;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_PATH  = 2'd1,
        PH_ARGS  = 2'd2,
        PH_TAIL  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        PD_SLASH = 2'd0,
        PD_ARGS  = 2'd1,
        PD_TAIL  = 2'd2,
        PD_FIN   = 2'd3
    } t_pend;

    typedef enum logic [2:0] {
        B_IDLE     = 3'd0,
        B_CLIMB_RD = 3'd1,
        B_CLIMB_CK = 3'd2,
        B_FIN      = 3'd3,
        B_EM_RD    = 3'd4,
        B_EM_CAP   = 3'd5,
        B_OUT      = 3'd6
    } t_bstate;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       empty;
        logic       is_slash;
        logic       is_dot;
        logic       is_pct;
        logic       is_qm;
        logic       is_hash;
        logic       is_plus;
        logic       is_digit;
        logic       hex_ok;
        logic [3:0] hex_val;
    } t_item;

endpackage

FILE: rtl/core/upn_front.sv
module upn_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_uri_byte,
    input  logic          i_last_byte,
    input  logic          i_empty_path,
    output logic          o_valid,
    input  logic          i_ready,
    output upn_pkg::t_item o_item
);
    import upn_pkg::*;

    logic  r_vld;
    t_item r_item;
    t_item n_item;
    logic [7:0] lc;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_comb begin
        lc               = i_uri_byte | CH_CASE;
        n_item.ch        = i_uri_byte;
        n_item.last      = i_last_byte;
        n_item.empty     = i_empty_path;
        n_item.is_slash  = (i_uri_byte == CH_SLASH);
        n_item.is_dot    = (i_uri_byte == CH_DOT);
        n_item.is_pct    = (i_uri_byte == CH_PCT);
        n_item.is_qm     = (i_uri_byte == CH_QM);
        n_item.is_hash   = (i_uri_byte == CH_HASH);
        n_item.is_plus   = (i_uri_byte == CH_PLUS);
        n_item.is_digit  = (i_uri_byte >= 8'h30) && (i_uri_byte <= 8'h39);
        n_item.hex_ok    = 1'b0;
        n_item.hex_val   = 4'd0;
        if (n_item.is_digit) begin
            n_item.hex_ok  = 1'b1;
            n_item.hex_val = 4'(i_uri_byte - 8'h30);
        end else if (lc >= 8'h61 && lc <= 8'h66) begin
            n_item.hex_ok  = 1'b1;
            n_item.hex_val = 4'(lc - 8'h57);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: rtl/core/upn_queue.sv
module upn_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  upn_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_pop,
    output upn_pkg::t_item o_item
);
    import upn_pkg::*;

    t_item r_mem [2];
    logic  r_wr;
    logic  r_rd;
    logic [1:0] r_cnt;
    logic  push;
    logic  pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= !r_wr;
            if (pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

FILE: rtl/core/upn_back.sv
module upn_back #(
    parameter int URI_MAX    = 256,
    parameter int WORD_BYTES = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_pop,
    input  upn_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [63:0]    o_out_bytes,
    output logic [3:0]     o_out_count,
    output logic           o_last_word,
    output logic [1:0]     o_status,
    output logic [8:0]     o_path_len,
    output logic           o_has_ext,
    output logic [8:0]     o_ext_offset,
    output logic [8:0]     o_ext_len,
    output logic           o_has_args,
    output logic [7:0]     o_args_offset,
    output logic [8:0]     o_args_len,
    output logic           o_plus_seen
);
    import upn_pkg::*;

    localparam int WPW = $clog2(URI_MAX + 1);
    localparam int AW  = $clog2(URI_MAX);
    localparam logic [WPW-1:0] UMAX = WPW'(URI_MAX);
    localparam logic [3:0]     WB   = 4'(WORD_BYTES);

    logic [7:0] r_mem [URI_MAX];
    logic [7:0] r_rdata;

    t_bstate  r_bst,   n_bst;
    logic [WPW-1:0] r_wp, n_wp;
    t_pstate  r_ps,    n_ps;
    t_pstate  r_saved, n_saved;
    logic [3:0] r_hn,  n_hn;
    logic [WPW-1:0] r_extpos, n_extpos;
    logic     r_extv,  n_extv;
    logic [WPW-1:0] r_inpos, n_inpos;
    t_phase   r_phase, n_phase;
    logic [WPW-1:0] r_qs, n_qs;
    logic [WPW-1:0] r_ql, n_ql;
    logic     r_plus,  n_plus;
    t_err     r_err,   n_err;
    logic     r_args,  n_args;
    logic [WPW-1:0] r_p, n_p;
    t_pend    r_pend,  n_pend;
    logic     r_last,  n_last;
    logic [WPW-1:0] r_idx, n_idx;
    logic [3:0] r_cnt, n_cnt;
    logic [63:0] r_word, n_word;

    logic        r_ov,    n_ov;
    logic [63:0] r_obytes, n_obytes;
    logic [3:0]  r_ocount, n_ocount;
    logic        r_olast, n_olast;
    logic [1:0]  r_ostat, n_ostat;
    logic [8:0]  r_olen, n_olen;
    logic        r_oext, n_oext;
    logic [8:0]  r_oextoff, n_oextoff;
    logic [8:0]  r_oextlen, n_oextlen;
    logic        r_oargs, n_oargs;
    logic [7:0]  r_oargoff, n_oargoff;
    logic [8:0]  r_oarglen, n_oarglen;
    logic        r_oplus, n_oplus;

    logic           we;
    logic [7:0]     wdata;
    logic [AW-1:0]  rd_addr;
    logic           pop;

    t_pstate    hs;
    logic       hact;
    logic [7:0] hc;
    logic       c_slash, c_dot, c_qm, c_hash, c_plus;
    logic [7:0] dec;
    logic       put_req, back_req, climb_req, args_req, tail_req;
    logic [7:0] put_ch;
    logic [15:0] qs_w;

    assign o_pop         = pop;
    assign o_valid       = r_ov;
    assign o_out_bytes   = r_obytes;
    assign o_out_count   = r_ocount;
    assign o_last_word   = r_olast;
    assign o_status      = r_ostat;
    assign o_path_len    = r_olen;
    assign o_has_ext     = r_oext;
    assign o_ext_offset  = r_oextoff;
    assign o_ext_len     = r_oextlen;
    assign o_has_args    = r_oargs;
    assign o_args_offset = r_oargoff;
    assign o_args_len    = r_oarglen;
    assign o_plus_seen   = r_oplus;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_wp[AW-1:0]] <= wdata;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bst   <= B_IDLE;
            r_wp    <= '0;
            r_ps    <= PS_USUAL;
            r_saved <= PS_USUAL;
            r_hn    <= '0;
            r_extpos <= '0;
            r_extv  <= 1'b0;
            r_inpos <= '0;
            r_phase <= PH_FIRST;
            r_qs    <= '0;
            r_ql    <= '0;
            r_plus  <= 1'b0;
            r_err   <= ERR_OK;
            r_args  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_bst   <= n_bst;
            r_wp    <= n_wp;
            r_ps    <= n_ps;
            r_saved <= n_saved;
            r_hn    <= n_hn;
            r_extpos <= n_extpos;
            r_extv  <= n_extv;
            r_inpos <= n_inpos;
            r_phase <= n_phase;
            r_qs    <= n_qs;
            r_ql    <= n_ql;
            r_plus  <= n_plus;
            r_err   <= n_err;
            r_args  <= n_args;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p       <= n_p;
        r_pend    <= n_pend;
        r_last    <= n_last;
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_word    <= n_word;
        r_obytes  <= n_obytes;
        r_ocount  <= n_ocount;
        r_olast   <= n_olast;
        r_ostat   <= n_ostat;
        r_olen    <= n_olen;
        r_oext    <= n_oext;
        r_oextoff <= n_oextoff;
        r_oextlen <= n_oextlen;
        r_oargs   <= n_oargs;
        r_oargoff <= n_oargoff;
        r_oarglen <= n_oarglen;
        r_oplus   <= n_oplus;
    end

    always_comb begin
        n_bst = r_bst; n_wp = r_wp; n_ps = r_ps; n_saved = r_saved; n_hn = r_hn;
        n_extpos = r_extpos; n_extv = r_extv; n_inpos = r_inpos; n_phase = r_phase;
        n_qs = r_qs; n_ql = r_ql; n_plus = r_plus; n_err = r_err; n_args = r_args;
        n_p = r_p; n_pend = r_pend; n_last = r_last; n_idx = r_idx; n_cnt = r_cnt;
        n_word = r_word; n_ov = r_ov;
        n_obytes = r_obytes; n_ocount = r_ocount; n_olast = r_olast; n_ostat = r_ostat;
        n_olen = r_olen; n_oext = r_oext; n_oextoff = r_oextoff; n_oextlen = r_oextlen;
        n_oargs = r_oargs; n_oargoff = r_oargoff; n_oarglen = r_oarglen;
        n_oplus = r_oplus;
        we = 1'b0; wdata = i_item.ch; rd_addr = r_p[AW-1:0]; pop = 1'b0;
        hs = PS_USUAL; hact = 1'b0; hc = i_item.ch;
        c_slash = 1'b0; c_dot = 1'b0; c_qm = 1'b0; c_hash = 1'b0; c_plus = 1'b0;
        dec = {r_hn, i_item.hex_val};
        put_req = 1'b0; back_req = 1'b0; climb_req = 1'b0; args_req = 1'b0;
        tail_req = 1'b0; put_ch = i_item.ch;
        qs_w = 16'(r_qs);

        unique case (r_bst)
            B_IDLE: begin
                if (i_valid) begin
                    if (r_err != ERR_OK) begin
                        pop = 1'b1;
                        n_last = i_item.last;
                        if (i_item.last) n_bst = B_FIN;
                    end else if (r_inpos >= UMAX) begin
                        pop = 1'b1;
                        n_err = ERR_OVF;
                        n_last = i_item.last;
                        if (i_item.last) n_bst = B_FIN;
                    end else if (r_phase == PH_FIRST && i_item.empty) begin
                        we = 1'b1;
                        wdata = CH_SLASH;
                        n_wp = r_wp + 1'b1;
                        n_phase = PH_PATH;
                    end else begin
                        pop = 1'b1;
                        n_inpos = r_inpos + 1'b1;
                        n_last = i_item.last;
                        n_bst = i_item.last ? B_FIN : B_IDLE;
                        if (r_phase == PH_ARGS) begin
                            if (i_item.is_hash) n_phase = PH_TAIL;
                            else n_ql = r_ql + 1'b1;
                        end else if (r_phase != PH_TAIL) begin
                            n_phase = PH_PATH;
                            if (i_item.is_pct && (r_ps == PS_USUAL || r_ps == PS_SLASH
                                    || r_ps == PS_DOT || r_ps == PS_DOTDOT)) begin
                                n_saved = r_ps;
                                n_ps = PS_QUOTED;
                            end else if (r_ps == PS_QUOTED) begin
                                if (!i_item.hex_ok) n_err = ERR_ESC;
                                else begin
                                    n_hn = i_item.hex_val;
                                    n_ps = PS_QUOTED2;
                                end
                            end else if (r_ps == PS_QUOTED2) begin
                                if (!i_item.hex_ok) n_err = ERR_ESC;
                                else if (i_item.is_digit && (dec == CH_PCT || dec == CH_HASH)) begin
                                    n_ps = PS_USUAL;
                                    put_req = 1'b1;
                                    put_ch = dec;
                                end else if (i_item.is_digit && dec == CH_NUL) begin
                                    n_err = ERR_ESC;
                                end else if (!i_item.is_digit && dec == CH_QM) begin
                                    n_ps = PS_USUAL;
                                    put_req = 1'b1;
                                    put_ch = dec;
                                end else begin
                                    hact = 1'b1;
                                    hs = t_pstate'({1'b0, r_saved[1:0]});
                                    hc = dec;
                                    c_slash = (dec == CH_SLASH);
                                    c_dot = (dec == CH_DOT);
                                    c_plus = (dec == CH_PLUS);
                                end
                            end else begin
                                hact = 1'b1;
                                hs = r_ps;
                                c_slash = i_item.is_slash;
                                c_dot = i_item.is_dot;
                                c_qm = i_item.is_qm;
                                c_hash = i_item.is_hash;
                                c_plus = i_item.is_plus;
                            end
                        end
                        if (hact) begin
                            put_ch = hc;
                            priority case (1'b1)
                                (hs == PS_SLASH): begin
                                    if (c_slash) begin
                                    end else if (c_dot) begin
                                        n_ps = PS_DOT; put_req = 1'b1;
                                    end else if (c_qm) args_req = 1'b1;
                                    else if (c_hash) tail_req = 1'b1;
                                    else begin
                                        n_ps = PS_USUAL; put_req = 1'b1;
                                        if (c_plus) n_plus = 1'b1;
                                    end
                                end
                                (hs == PS_DOT): begin
                                    if (c_slash) begin
                                        n_ps = PS_SLASH; back_req = 1'b1;
                                    end else if (c_dot) begin
                                        n_ps = PS_DOTDOT; put_req = 1'b1;
                                    end else if (c_qm) begin
                                        back_req = 1'b1; args_req = 1'b1;
                                    end else if (c_hash) begin
                                        back_req = 1'b1; tail_req = 1'b1;
                                    end else begin
                                        n_ps = PS_USUAL; put_req = 1'b1;
                                        if (c_plus) n_plus = 1'b1;
                                    end
                                end
                                (hs == PS_DOTDOT): begin
                                    if (c_slash || c_qm || c_hash) begin
                                        climb_req = 1'b1;
                                        n_ps = PS_SLASH;
                                        n_pend = c_qm ? PD_ARGS : (c_hash ? PD_TAIL : PD_SLASH);
                                    end else begin
                                        n_ps = PS_USUAL; put_req = 1'b1;
                                        if (c_plus) n_plus = 1'b1;
                                    end
                                end
                                default: begin
                                    n_ps = PS_USUAL;
                                    if (c_slash) begin
                                        n_extv = 1'b0; n_ps = PS_SLASH; put_req = 1'b1;
                                    end else if (c_qm) args_req = 1'b1;
                                    else if (c_hash) tail_req = 1'b1;
                                    else if (c_dot) begin
                                        put_req = 1'b1;
                                        n_extpos = r_wp + 1'b1;
                                        n_extv = 1'b1;
                                    end else begin
                                        put_req = 1'b1;
                                        if (c_plus) n_plus = 1'b1;
                                    end
                                end
                            endcase
                        end
                        if (put_req) begin
                            if (r_wp >= UMAX) n_err = ERR_OVF;
                            else begin
                                we = 1'b1;
                                wdata = put_ch;
                                n_wp = r_wp + 1'b1;
                            end
                        end
                        if (back_req && r_wp != '0) n_wp = r_wp - 1'b1;
                        if (args_req) begin
                            n_phase = PH_ARGS; n_args = 1'b1;
                            n_qs = r_inpos + 1'b1; n_ql = '0;
                        end
                        if (tail_req) n_phase = PH_TAIL;
                        if (climb_req) begin
                            if (r_wp < WPW'(4)) n_err = ERR_ROOT;
                            else begin
                                n_p = r_wp - WPW'(4);
                                n_bst = B_CLIMB_RD;
                            end
                        end
                    end
                end
            end
            B_CLIMB_RD: begin
                rd_addr = r_p[AW-1:0];
                n_bst = B_CLIMB_CK;
            end
            B_CLIMB_CK: begin
                if (r_rdata == CH_SLASH) begin
                    n_wp = r_p + 1'b1;
                    unique case (r_pend)
                        PD_ARGS: begin
                            n_phase = PH_ARGS; n_args = 1'b1;
                            n_qs = r_inpos; n_ql = '0;
                        end
                        PD_TAIL:  n_phase = PH_TAIL;
                        PD_SLASH: n_ps = PS_SLASH;
                        PD_FIN:   ;
                    endcase
                    if (r_pend == PD_FIN) begin
                        n_idx = '0; n_cnt = '0; n_word = '0; n_bst = B_EM_RD;
                    end else n_bst = r_last ? B_FIN : B_IDLE;
                end else if (r_p == '0) begin
                    n_err = ERR_ROOT;
                    if (r_pend == PD_FIN) begin
                        n_idx = '0; n_cnt = '0; n_word = '0; n_bst = B_EM_RD;
                    end else n_bst = r_last ? B_FIN : B_IDLE;
                end else begin
                    n_p = r_p - 1'b1;
                    n_bst = B_CLIMB_RD;
                end
            end
            B_FIN: begin
                n_idx = '0; n_cnt = '0; n_word = '0;
                n_bst = B_EM_RD;
                if (r_err == ERR_OK && r_phase == PH_PATH) begin
                    if (r_ps == PS_QUOTED || r_ps == PS_QUOTED2) n_err = ERR_ESC;
                    else if (r_ps == PS_DOT) begin
                        if (r_wp != '0) n_wp = r_wp - 1'b1;
                    end else if (r_ps == PS_DOTDOT) begin
                        if (r_wp < WPW'(4)) n_err = ERR_ROOT;
                        else begin
                            n_p = r_wp - WPW'(4);
                            n_pend = PD_FIN;
                            n_bst = B_CLIMB_RD;
                        end
                    end
                end
            end
            B_EM_RD: begin
                if (r_err != ERR_OK) begin
                    n_obytes = '0; n_ocount = '0; n_olast = 1'b1; n_ostat = r_err;
                    n_olen = '0; n_oext = 1'b0; n_oextoff = '0; n_oextlen = '0;
                    n_oargs = 1'b0; n_oargoff = '0; n_oarglen = '0; n_oplus = 1'b0;
                    n_ov = 1'b1; n_bst = B_OUT;
                end else if (r_cnt < WB && r_idx < r_wp) begin
                    rd_addr = r_idx[AW-1:0];
                    n_bst = B_EM_CAP;
                end else begin
                    n_obytes = r_word; n_ocount = r_cnt; n_olast = (r_idx >= r_wp);
                    n_ostat = ERR_OK; n_olen = 9'(r_wp);
                    if (r_extv && r_extpos <= r_wp) begin
                        n_oext = 1'b1; n_oextoff = 9'(r_extpos);
                        n_oextlen = 9'(r_wp - r_extpos);
                    end else begin
                        n_oext = 1'b0; n_oextoff = '0; n_oextlen = '0;
                    end
                    if (r_args) begin
                        n_oargs = 1'b1;
                        n_oargoff = (qs_w > 16'd255) ? 8'd255 : qs_w[7:0];
                        n_oarglen = 9'(r_ql);
                    end else begin
                        n_oargs = 1'b0; n_oargoff = '0; n_oarglen = '0;
                    end
                    n_oplus = r_plus;
                    n_ov = 1'b1; n_bst = B_OUT;
                end
            end
            B_EM_CAP: begin
                n_word[8*r_cnt[2:0] +: 8] = r_rdata;
                n_cnt = r_cnt + 1'b1;
                n_idx = r_idx + 1'b1;
                n_bst = B_EM_RD;
            end
            B_OUT: begin
                if (i_ready) begin
                    n_ov = 1'b0;
                    if (r_olast) begin
                        n_bst = B_IDLE;
                        n_wp = '0; n_ps = PS_USUAL; n_saved = PS_USUAL; n_hn = '0;
                        n_extpos = '0; n_extv = 1'b0; n_inpos = '0; n_phase = PH_FIRST;
                        n_qs = '0; n_ql = '0; n_plus = 1'b0; n_err = ERR_OK; n_args = 1'b0;
                    end else begin
                        n_word = '0; n_cnt = '0; n_bst = B_EM_RD;
                    end
                end
            end
            default: n_bst = B_IDLE;
        endcase
    end

endmodule

FILE: rtl/core/uri_path_normalizer_unit.sv
// A byte transfer is registered in the front end and passes the item queue to the back
// end; a "../" walk reads and checks each path store entry visited (store read port).
// Throughput: one byte per cycle between walks, held off while an empty-path lead is
// written or a URI is emitted. Emit: the URI is closed, then each path byte is read and
// captured and each result word is offered, one word held until taken.
// Reset: synchronous active-low i_rst_n clears state, write pointers and flags; the path
// store, walk, emit and output registers are not cleared and are written before read.
module uri_path_normalizer_unit #(
    parameter int URI_MAX    = 256,
    parameter int WORD_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_uri_byte,
    input  logic        i_last_byte,
    input  logic        i_empty_path,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_out_bytes,
    output logic [3:0]  o_out_count,
    output logic        o_last_word,
    output logic [1:0]  o_status,
    output logic [8:0]  o_path_len,
    output logic        o_has_ext,
    output logic [8:0]  o_ext_offset,
    output logic [8:0]  o_ext_len,
    output logic        o_has_args,
    output logic [7:0]  o_args_offset,
    output logic [8:0]  o_args_len,
    output logic        o_plus_seen
);
    import upn_pkg::*;

    logic  f_valid;
    logic  f_ready;
    t_item f_item;
    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    upn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_uri_byte  (i_uri_byte),
        .i_last_byte (i_last_byte),
        .i_empty_path(i_empty_path),
        .o_valid     (f_valid),
        .i_ready     (f_ready),
        .o_item      (f_item)
    );

    upn_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(f_valid),
        .o_ready(f_ready),
        .i_item (f_item),
        .o_valid(q_valid),
        .i_pop  (q_pop),
        .o_item (q_item)
    );

    upn_back #(
        .URI_MAX   (URI_MAX),
        .WORD_BYTES(WORD_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .o_pop        (q_pop),
        .i_item       (q_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_bytes  (o_out_bytes),
        .o_out_count  (o_out_count),
        .o_last_word  (o_last_word),
        .o_status     (o_status),
        .o_path_len   (o_path_len),
        .o_has_ext    (o_has_ext),
        .o_ext_offset (o_ext_offset),
        .o_ext_len    (o_ext_len),
        .o_has_args   (o_has_args),
        .o_args_offset(o_args_offset),
        .o_args_len   (o_args_len),
        .o_plus_seen  (o_plus_seen)
    );

endmodule

FILE: bench/tb_uri_path_normalizer_unit.sv
`timescale 1ns / 100ps

module tb_uri_path_normalizer_unit;
    import upn_pkg::*;

    localparam int PATH_MAX   = 256;
    localparam int WORD_LEN   = 8;
    localparam int CYCLE_CAP  = 900000;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        last;
        logic [1:0]  status;
        logic [8:0]  path_len;
        logic        has_ext;
        logic [8:0]  ext_offset;
        logic [8:0]  ext_len;
        logic        has_args;
        logic [7:0]  args_offset;
        logic [8:0]  args_len;
        logic        plus;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_uri_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        i_empty_path = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_out_bytes;
    logic [3:0]  o_out_count;
    logic        o_last_word;
    logic [1:0]  o_status;
    logic [8:0]  o_path_len;
    logic        o_has_ext;
    logic [8:0]  o_ext_offset;
    logic [8:0]  o_ext_len;
    logic        o_has_args;
    logic [7:0]  o_args_offset;
    logic [8:0]  o_args_len;
    logic        o_plus_seen;

    uri_path_normalizer_unit dut (.*);

    always #1 i_clk = ~i_clk;

    // normaliser state mirrored in the bench
    logic [7:0] m_store [PATH_MAX];
    int unsigned m_wpos, m_extpos, m_inpos, m_qstart, m_qlen;
    t_pstate     m_ps, m_saved;
    logic [3:0]  m_hi;
    logic        m_extv, m_plus, m_args;
    t_phase      m_phase;
    t_err        m_err;

    t_word       pending_words [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          hold_off = 1'b0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatch_count++;
        $display("MISMATCH %s: got %0h, want %0h at cycle %0d", what, got, want, cycle_count);
    endtask

    function automatic void set_err(t_err e);
        if (m_err == ERR_OK) m_err = e;
    endfunction

    function automatic void put(logic [7:0] b);
        if (m_wpos >= PATH_MAX) begin
            set_err(ERR_OVF);
            return;
        end
        m_store[m_wpos] = b;
        m_wpos++;
    endfunction

    function automatic void climb();
        int p;
        if (m_wpos < 4) begin
            set_err(ERR_ROOT);
            return;
        end
        p = m_wpos - 4;
        forever begin
            if (m_store[p] == CH_SLASH) begin
                m_wpos = p + 1;
                return;
            end
            if (p == 0) begin
                set_err(ERR_ROOT);
                return;
            end
            p--;
        end
    endfunction

    function automatic void open_args();
        m_phase = PH_ARGS;
        m_args = 1'b1;
        m_qstart = m_inpos + 1;
        m_qlen = 0;
    endfunction

    function automatic int hex_of(logic [7:0] ch);
        logic [7:0] c;
        c = ch | CH_CASE;
        if (ch >= "0" && ch <= "9") return ch - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return -1;
    endfunction

    function automatic void plain(logic [7:0] ch);
        if (ch == CH_PLUS) m_plus = 1'b1;
        m_ps = PS_USUAL;
        put(ch);
    endfunction

    function automatic void path_char(logic [7:0] ch_in);
        logic [7:0] ch;
        logic [7:0] d;
        int v;
        ch = ch_in;
        forever begin
            if (m_ps <= PS_DOTDOT && ch == CH_PCT) begin
                m_saved = m_ps;
                m_ps = PS_QUOTED;
                return;
            end
            case (m_ps)
                PS_USUAL: begin
                    if (ch == CH_SLASH) begin
                        m_extv = 1'b0;
                        m_ps = PS_SLASH;
                        put(CH_SLASH);
                    end else if (ch == CH_QM) open_args();
                    else if (ch == CH_HASH) m_phase = PH_TAIL;
                    else if (ch == CH_DOT) begin
                        put(CH_DOT);
                        m_extpos = m_wpos;
                        m_extv = 1'b1;
                    end else plain(ch);
                    return;
                end
                PS_SLASH: begin
                    if (ch == CH_SLASH) ;
                    else if (ch == CH_DOT) begin
                        m_ps = PS_DOT;
                        put(CH_DOT);
                    end else if (ch == CH_QM) open_args();
                    else if (ch == CH_HASH) m_phase = PH_TAIL;
                    else plain(ch);
                    return;
                end
                PS_DOT: begin
                    if (ch == CH_SLASH) begin
                        m_ps = PS_SLASH;
                        if (m_wpos > 0) m_wpos--;
                    end else if (ch == CH_DOT) begin
                        m_ps = PS_DOTDOT;
                        put(CH_DOT);
                    end else if (ch == CH_QM) begin
                        if (m_wpos > 0) m_wpos--;
                        open_args();
                    end else if (ch == CH_HASH) begin
                        if (m_wpos > 0) m_wpos--;
                        m_phase = PH_TAIL;
                    end else plain(ch);
                    return;
                end
                PS_DOTDOT: begin
                    if (ch == CH_SLASH || ch == CH_QM || ch == CH_HASH) begin
                        climb();
                        if (m_err != ERR_OK) return;
                        if (ch == CH_QM) open_args();
                        else if (ch == CH_HASH) m_phase = PH_TAIL;
                        else m_ps = PS_SLASH;
                    end else plain(ch);
                    return;
                end
                PS_QUOTED: begin
                    v = hex_of(ch);
                    if (v < 0) begin
                        set_err(ERR_ESC);
                        return;
                    end
                    m_hi = v[3:0];
                    m_ps = PS_QUOTED2;
                    return;
                end
                default: begin
                    v = hex_of(ch);
                    if (v < 0) begin
                        set_err(ERR_ESC);
                        return;
                    end
                    d = {m_hi, v[3:0]};
                    if (ch >= "0" && ch <= "9") begin
                        if (d == CH_PCT || d == CH_HASH) begin
                            m_ps = PS_USUAL;
                            put(d);
                            return;
                        end
                        if (d == CH_NUL) begin
                            set_err(ERR_ESC);
                            return;
                        end
                    end else begin
                        if (d == CH_QM) begin
                            m_ps = PS_USUAL;
                            put(d);
                            return;
                        end
                        if (d == CH_PLUS) m_plus = 1'b1;
                    end
                    m_ps = t_pstate'({1'b0, m_saved[1:0]});
                    ch = d;
                end
            endcase
        end
    endfunction

    function automatic void clear_uri();
        m_wpos = 0; m_ps = PS_USUAL; m_saved = PS_USUAL; m_hi = '0;
        m_extpos = 0; m_extv = 1'b0; m_inpos = 0; m_phase = PH_FIRST;
        m_qstart = 0; m_qlen = 0; m_plus = 1'b0; m_err = ERR_OK; m_args = 1'b0;
    endfunction

    function automatic void normalise_byte(logic [7:0] b, logic last, logic empty);
        int unsigned len, n;
        t_word w;
        if (m_err == ERR_OK) begin
            if (m_inpos >= PATH_MAX) set_err(ERR_OVF);
            else begin
                if (m_phase == PH_FIRST) begin
                    if (empty) put(CH_SLASH);
                    m_phase = PH_PATH;
                end
                if (m_err == ERR_OK) begin
                    if (m_phase == PH_PATH) path_char(b);
                    else if (m_phase == PH_ARGS) begin
                        if (b == CH_HASH) m_phase = PH_TAIL;
                        else m_qlen++;
                    end
                end
                m_inpos++;
            end
        end
        if (!last) return;
        if (m_err == ERR_OK && m_phase == PH_PATH) begin
            if (m_ps == PS_QUOTED || m_ps == PS_QUOTED2) set_err(ERR_ESC);
            else if (m_ps == PS_DOT) begin
                if (m_wpos > 0) m_wpos--;
            end else if (m_ps == PS_DOTDOT) climb();
        end
        if (m_err != ERR_OK) begin
            w = '0;
            w.last = 1'b1;
            w.status = m_err;
            pending_words.push_back(w);
            clear_uri();
            return;
        end
        len = m_wpos;
        n = (len + WORD_LEN - 1) / WORD_LEN;
        if (n == 0) n = 1;
        for (int k = 0; k < n; k++) begin
            w = '0;
            for (int i = 0; i < WORD_LEN && k * WORD_LEN + i < len; i++) begin
                w.bytes[8*i +: 8] = m_store[k * WORD_LEN + i];
                w.count++;
            end
            w.last = (k + 1 == n);
            w.path_len = 9'(len);
            if (m_extv && m_extpos <= len) begin
                w.has_ext = 1'b1;
                w.ext_offset = 9'(m_extpos);
                w.ext_len = 9'(len - m_extpos);
            end
            if (m_args) begin
                w.has_args = 1'b1;
                w.args_offset = (m_qstart > 255) ? 8'd255 : m_qstart[7:0];
                w.args_len = 9'(m_qlen);
            end
            w.plus = m_plus;
            pending_words.push_back(w);
        end
        clear_uri();
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input logic empty);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_uri_byte <= b;
        i_last_byte <= last;
        i_empty_path <= empty;
        do @(posedge i_clk); while (!o_ready);
        normalise_byte(b, last, empty);
    endtask

    task automatic send_uri(input string s, input logic empty);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1, empty);
    endtask

    // receiver with random stalls
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off) i_ready <= 1'b0;
            else i_ready <= ($urandom_range(0, 6) == 0) ? 1'b0 : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_word w;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_words.size() == 0) report("unexpected transfer", 0, 0);
            else begin
                w = pending_words.pop_front();
                if (o_out_bytes !== w.bytes) report("out_bytes", o_out_bytes, w.bytes);
                if (o_out_count !== w.count) report("out_count", o_out_count, w.count);
                if (o_last_word !== w.last) report("last_word", o_last_word, w.last);
                if (o_status !== w.status) report("status", o_status, w.status);
                if (o_path_len !== w.path_len) report("path_len", o_path_len, w.path_len);
                if (o_has_ext !== w.has_ext) report("has_ext", o_has_ext, w.has_ext);
                if (o_ext_offset !== w.ext_offset)
                    report("ext_offset", o_ext_offset, w.ext_offset);
                if (o_ext_len !== w.ext_len) report("ext_len", o_ext_len, w.ext_len);
                if (o_has_args !== w.has_args) report("has_args", o_has_args, w.has_args);
                if (o_args_offset !== w.args_offset)
                    report("args_offset", o_args_offset, w.args_offset);
                if (o_args_len !== w.args_len) report("args_len", o_args_len, w.args_len);
                if (o_plus_seen !== w.plus) report("plus_seen", o_plus_seen, w.plus);
            end
        end
        if (cycle_count > CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic test_directed();
        send_uri("/a/./b/../c.txt?x=1#frag", 1'b0);
        send_uri("//x%2Fy/%41%2b+%3F%23%25", 1'b0);
        send_uri("a.b.c", 1'b1);
        send_uri("/..", 1'b0);
        send_uri("/%zz", 1'b0);
        send_uri("/%00", 1'b0);
        send_uri("/ab%4", 1'b0);
        send_uri("/a/.", 1'b0);
        send_uri("?", 1'b0);
        send_uri("#", 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h80, 1'b1, 1'b0);
        send_uri("/q/..?z#", 1'b0);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 11))
            0, 1: return CH_SLASH;
            2, 3: return CH_DOT;
            4: return CH_PCT;
            5: return 8'("0" + $urandom_range(0, 9));
            6: return 8'("a" + $urandom_range(0, 5));
            7: return 8'("A" + $urandom_range(0, 5));
            8: return ($urandom_range(0, 3) == 0) ? CH_QM : CH_PLUS;
            9: return ($urandom_range(0, 4) == 0) ? CH_HASH : 8'("x");
            10: return 8'($urandom_range(0, 255));
            default: return 8'("a" + $urandom_range(0, 25));
        endcase
    endfunction

    task automatic test_random();
        int len;
        for (int u = 0; u < 11; u++) begin
            len = $urandom_range(1, 16);
            if (u == 4) hold_off = 1'b1;
            for (int i = 0; i < len; i++)
                send_byte(pick_char(), i == len - 1, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        fork
            test_random();
            begin
                wait (hold_off);
                repeat (120) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        i_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && pending_words.size() == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
